[rtl/core/btpc_pkg.sv]
// Package for the barometric temperature and pressure compensation block.
// Holds the beat and calibration types, inter-stage types and fixed constants.
// No dependencies.
`default_nettype none

package btpc_pkg;

	// Register indexes on the configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE_SENSITIVITY   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE_OFFSET        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SENSITIVITY_TEMP_COEFF = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_TEMP_COEFF      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE_TEMPERATURE  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_TEMPERATURE_SLOPE      = 3'd5;

	// Temperature thresholds in hundredths of a degree.
	localparam logic signed [19:0] TEMP_REF   = 20'sd2000;
	localparam int                 TEMP_LIMIT = 300000;

	// Saturation limits of the pressure result.
	localparam int PRES_MAX = 8388607;
	localparam int PRES_MIN = -8388608;

	typedef struct packed {
		logic [15:0] pressure_sensitivity;
		logic [15:0] pressure_offset;
		logic [15:0] sensitivity_temp_coeff;
		logic [15:0] offset_temp_coeff;
		logic [15:0] reference_temperature;
		logic [15:0] temperature_slope;
	} cal_t;

	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} in_beat_t;

	typedef struct packed {
		logic signed [19:0] temperature_centi;
		logic signed [23:0] pressure_centi;
	} out_beat_t;

	// First-order results handed to the second-order stages.
	typedef struct packed {
		logic [23:0]        d1;
		logic signed [19:0] temp;
		logic signed [40:0] off;
		logic signed [40:0] sens;
		logic [17:0]        t2;
	} first_t;

	// Corrected terms handed to the pressure stages.
	typedef struct packed {
		logic [23:0]        d1;
		logic signed [19:0] temp;
		logic signed [40:0] off;
		logic signed [40:0] sens;
	} corr_t;

endpackage

`default_nettype wire

[rtl/core/btpc_first.sv]
// First-order compensation: temperature difference, the four products on it,
// and the first-order temperature, offset and sensitivity. Uses btpc_pkg.
`default_nettype none

module btpc_first (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire btpc_pkg::cal_t    cal,
	input  wire logic              up_valid,
	output logic                   up_ready,
	input  wire btpc_pkg::in_beat_t up_data,
	output logic                   dn_valid,
	input  wire logic              dn_ready,
	output btpc_pkg::first_t       dn_data
);
	import btpc_pkg::*;

	logic en_s1, en_s2, en_s3;
	logic v_s1, v_s2, v_s3;

	logic [23:0]        d1_s1, d1_s2, d1_s3;
	logic signed [24:0] dt_s1;
	logic signed [41:0] pt_s2, po_s2, ps_s2;
	logic signed [49:0] dd_s2;
	logic signed [19:0] temp_s3;
	logic signed [40:0] off_s3, sens_s3;
	logic [17:0]        t2_s3;

	logic signed [16:0] slope_x, ocoef_x, scoef_x;
	logic signed [41:0] pt_adj, po_adj, ps_adj;
	logic signed [18:0] pt_div;
	logic signed [34:0] po_div;
	logic signed [33:0] ps_div;

	assign en_s3    = !v_s3 || dn_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign up_ready = en_s1;

	assign slope_x = $signed({1'b0, cal.temperature_slope});
	assign ocoef_x = $signed({1'b0, cal.offset_temp_coeff});
	assign scoef_x = $signed({1'b0, cal.sensitivity_temp_coeff});

	// Divisions by powers of two truncate toward zero: bias negatives first.
	assign pt_adj = pt_s2 + (pt_s2[41] ? 42'sd8388607 : 42'sd0);
	assign po_adj = po_s2 + (po_s2[41] ? 42'sd127 : 42'sd0);
	assign ps_adj = ps_s2 + (ps_s2[41] ? 42'sd255 : 42'sd0);
	assign pt_div = pt_adj[41:23];
	assign po_div = po_adj[41:7];
	assign ps_div = ps_adj[41:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d1_s1 <= up_data.raw_pressure;
			dt_s1 <= $signed({1'b0, up_data.raw_temperature})
				- $signed({1'b0, cal.reference_temperature, 8'b0});
		end
		if (en_s2) begin
			d1_s2 <= d1_s1;
			pt_s2 <= dt_s1 * slope_x;
			po_s2 <= dt_s1 * ocoef_x;
			ps_s2 <= dt_s1 * scoef_x;
			dd_s2 <= dt_s1 * dt_s1;
		end
		if (en_s3) begin
			d1_s3   <= d1_s2;
			temp_s3 <= TEMP_REF + $signed({pt_div[18], pt_div});
			off_s3  <= $signed({9'b0, cal.pressure_offset, 16'b0})
				+ $signed({{6{po_div[34]}}, po_div});
			sens_s3 <= $signed({10'b0, cal.pressure_sensitivity, 15'b0})
				+ $signed({{7{ps_div[33]}}, ps_div});
			t2_s3   <= dd_s2[48:31];
		end
	end

	assign dn_valid     = v_s3;
	assign dn_data.d1   = d1_s3;
	assign dn_data.temp = temp_s3;
	assign dn_data.off  = off_s3;
	assign dn_data.sens = sens_s3;
	assign dn_data.t2   = t2_s3;

endmodule

`default_nettype wire

[rtl/core/btpc_second.sv]
// Second-order correction below 20.00 C, stronger below -15.00 C, applied
// to temperature, offset and sensitivity. Uses btpc_pkg.
`default_nettype none

module btpc_second (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            up_valid,
	output logic                 up_ready,
	input  wire btpc_pkg::first_t up_data,
	output logic                 dn_valid,
	input  wire logic            dn_ready,
	output btpc_pkg::corr_t      dn_data
);
	import btpc_pkg::*;

	logic en_s4, en_s5, en_s6;
	logic v_s4, v_s5, v_s6;

	logic [23:0]        d1_s4, d1_s5, d1_s6;
	logic signed [19:0] temp_s4, temp_s5, temp_s6;
	logic signed [40:0] off_s4, off_s5, off_s6;
	logic signed [40:0] sens_s4, sens_s5, sens_s6;
	logic [17:0]        t2_s4, t2_s5;
	logic [34:0]        aa_s4;
	logic [35:0]        bb_s4;
	logic               lt2000_s4, lt1500_s4;
	logic [38:0]        off2_s5, sens2_s5;

	logic signed [19:0] a_diff, b_diff;
	logic signed [39:0] aa_full, bb_full;
	logic [36:0]        five_aa;
	logic [38:0]        seven_bb;
	logic [39:0]        eleven_bb;
	logic [39:0]        off2_sum, sens2_sum;

	assign en_s6    = !v_s6 || dn_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign up_ready = en_s4;

	assign a_diff  = up_data.temp - TEMP_REF;
	assign b_diff  = up_data.temp + 20'sd1500;
	assign aa_full = a_diff * a_diff;
	assign bb_full = b_diff * b_diff;

	// Constant multiples as shift and add; squares are never negative.
	assign five_aa   = {aa_s4, 2'b0} + {2'b0, aa_s4};
	assign seven_bb  = {bb_s4, 3'b0} - {3'b0, bb_s4};
	assign eleven_bb = {1'b0, bb_s4, 3'b0} + {3'b0, bb_s4, 1'b0} + {4'b0, bb_s4};
	assign off2_sum  = {4'b0, five_aa[36:1]} + (lt1500_s4 ? {1'b0, seven_bb} : 40'd0);
	assign sens2_sum = {5'b0, five_aa[36:2]} + (lt1500_s4 ? {1'b0, eleven_bb[39:1]} : 40'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= up_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			d1_s4     <= up_data.d1;
			temp_s4   <= up_data.temp;
			off_s4    <= up_data.off;
			sens_s4   <= up_data.sens;
			t2_s4     <= up_data.t2;
			aa_s4     <= aa_full[34:0];
			bb_s4     <= bb_full[35:0];
			lt2000_s4 <= a_diff[19];
			lt1500_s4 <= b_diff[19];
		end
		if (en_s5) begin
			d1_s5    <= d1_s4;
			temp_s5  <= temp_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			t2_s5    <= lt2000_s4 ? t2_s4 : 18'd0;
			off2_s5  <= lt2000_s4 ? off2_sum[38:0] : 39'd0;
			sens2_s5 <= lt2000_s4 ? sens2_sum[38:0] : 39'd0;
		end
		if (en_s6) begin
			d1_s6   <= d1_s5;
			temp_s6 <= temp_s5 - $signed({2'b0, t2_s5});
			off_s6  <= off_s5 - $signed({2'b0, off2_s5});
			sens_s6 <= sens_s5 - $signed({2'b0, sens2_s5});
		end
	end

	assign dn_valid     = v_s6;
	assign dn_data.d1   = d1_s6;
	assign dn_data.temp = temp_s6;
	assign dn_data.off  = off_s6;
	assign dn_data.sens = sens_s6;

`ifndef SYNTHESIS
	// The colder branch is only ever taken inside the cold branch.
	a_cold_nested: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && lt1500_s4) |-> lt2000_s4)
		else $error("cold correction flagged without the base correction");
	// No correction terms survive for a warm item.
	a_warm_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en_s5 && !lt2000_s4) |=> (off2_s5 == 39'd0 && sens2_s5 == 39'd0
			&& t2_s5 == 18'd0))
		else $error("second-order terms applied above the threshold");
`endif

endmodule

`default_nettype wire

[rtl/core/btpc_press.sv]
// Pressure from the corrected sensitivity and offset, with saturation of
// both results into the output register. Uses btpc_pkg.
`default_nettype none

module btpc_press (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              up_valid,
	output logic                   up_ready,
	input  wire btpc_pkg::corr_t   up_data,
	output logic                   dn_valid,
	input  wire logic              dn_ready,
	output btpc_pkg::out_beat_t    dn_data
);
	import btpc_pkg::*;

	logic en_s7, en_s8, en_s9, en_s10;
	logic v_s7, v_s8, v_s9, v_s10;

	logic signed [19:0] temp_s7, temp_s8, temp_s9;
	logic signed [40:0] off_s7, off_s8;
	logic [44:0]        plo_s7;
	logic signed [44:0] phi_s7;
	logic signed [45:0] q_s8;
	logic signed [46:0] r_s9;
	out_beat_t          out_s10;

	logic signed [19:0] sens_hi;
	logic [20:0]        sens_lo;
	logic signed [46:0] r_adj;
	logic signed [31:0] p_full;
	logic signed [23:0] p_sat;
	logic signed [19:0] t_sat;

	assign en_s10   = !v_s10 || dn_ready;
	assign en_s9    = !v_s9 || en_s10;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign up_ready = en_s7;

	// The 41-bit sensitivity is split so each product stays near 24 by 21.
	assign sens_lo = up_data.sens[20:0];
	assign sens_hi = up_data.sens[40:21];

	// Division by 2^15 truncates toward zero.
	assign r_adj  = r_s9 + (r_s9[46] ? 47'sd32767 : 47'sd0);
	assign p_full = r_adj[46:15];

	always_comb begin
		if (p_full > PRES_MAX) begin
			p_sat = 24'(PRES_MAX);
		end else if (p_full < PRES_MIN) begin
			p_sat = 24'(PRES_MIN);
		end else begin
			p_sat = p_full[23:0];
		end
		if (temp_s9 > TEMP_LIMIT) begin
			t_sat = 20'(TEMP_LIMIT);
		end else if (temp_s9 < -TEMP_LIMIT) begin
			t_sat = 20'(-TEMP_LIMIT);
		end else begin
			t_sat = temp_s9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (en_s7)  v_s7  <= up_valid;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			temp_s7 <= up_data.temp;
			off_s7  <= up_data.off;
			plo_s7  <= up_data.d1 * sens_lo;
			phi_s7  <= $signed({1'b0, up_data.d1}) * sens_hi;
		end
		if (en_s8) begin
			temp_s8 <= temp_s7;
			off_s8  <= off_s7;
			// Floor of the full product over 2^21: the low part is never negative.
			q_s8    <= $signed({phi_s7[44], phi_s7}) + $signed({22'b0, plo_s7[44:21]});
		end
		if (en_s9) begin
			temp_s9 <= temp_s8;
			r_s9    <= $signed({q_s8[45], q_s8}) - $signed({{6{off_s8[40]}}, off_s8});
		end
		if (en_s10) begin
			out_s10.temperature_centi <= t_sat;
			out_s10.pressure_centi    <= p_sat;
		end
	end

	assign dn_valid = v_s10;
	assign dn_data  = out_s10;

endmodule

`default_nettype wire

[rtl/core/baro_temp_pressure_compensation_top.sv]
// Top level of the barometric temperature and pressure compensation block.
// Holds the calibration registers and chains btpc_first, btpc_second and btpc_press.
`default_nettype none

// Each input beat carries one raw 24-bit pressure and one raw 24-bit temperature
// conversion; each output beat carries the compensated temperature in 0.01 C and
// the pressure in 0.01 mbar, both two's complement, pressure saturated to 24 bits.
// The datapath is a ten-stage pipeline: three stages form the first-order terms,
// three add the second-order correction below 20.00 C (stronger below -15.00 C),
// and four form and saturate the pressure, the last one being the output register.
// A beat moves through the stages in order until the output register offers it, and the
// block accepts one beat every cycle for as long as the output is taken. Each stage
// holds its beat while the stage after it is full and stalled, so a stall at the
// output fills empty stages before the input stops. The six calibration words are
// written through the configuration port, which is always ready; index values above
// five are ignored and write nothing. Write them only while no beat is in flight.
module baro_temp_pressure_compensation_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [btpc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [15:0]                           cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire btpc_pkg::in_beat_t                    in_data,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output btpc_pkg::out_beat_t                        out_data
);
	import btpc_pkg::*;

	cal_t   cal_q;
	first_t first_data;
	corr_t  corr_data;
	logic   first_valid, first_ready;
	logic   corr_valid, corr_ready;

	assign cfg_ready = 1'b1;

	// Calibration words; they reset to zero like the sensor before its PROM is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PRESSURE_SENSITIVITY:   cal_q.pressure_sensitivity   <= cfg_data;
				CFG_PRESSURE_OFFSET:        cal_q.pressure_offset        <= cfg_data;
				CFG_SENSITIVITY_TEMP_COEFF: cal_q.sensitivity_temp_coeff <= cfg_data;
				CFG_OFFSET_TEMP_COEFF:      cal_q.offset_temp_coeff      <= cfg_data;
				CFG_REFERENCE_TEMPERATURE:  cal_q.reference_temperature  <= cfg_data;
				CFG_TEMPERATURE_SLOPE:      cal_q.temperature_slope      <= cfg_data;
				default: ;
			endcase
		end
	end

	btpc_first u_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.cal      (cal_q),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.up_data  (in_data),
		.dn_valid (first_valid),
		.dn_ready (first_ready),
		.dn_data  (first_data)
	);

	btpc_second u_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (first_valid),
		.up_ready (first_ready),
		.up_data  (first_data),
		.dn_valid (corr_valid),
		.dn_ready (corr_ready),
		.dn_data  (corr_data)
	);

	btpc_press u_press (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (corr_valid),
		.up_ready (corr_ready),
		.up_data  (corr_data),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_data  (out_data)
	);

`ifndef SYNTHESIS
	// A free-running output must never hold back the input.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while the output is being taken");
	// The temperature stays inside its clamp on every delivered beat.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.temperature_centi >= -TEMP_LIMIT
			&& out_data.temperature_centi <= TEMP_LIMIT))
		else $error("temperature outside its range");
`endif

endmodule

`default_nettype wire
